/* sv/assert_macros.svh */
// assertion macros shared by the scanner rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, masked while reset is applied
`define PCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// concurrent check on the rising clock that also holds during reset
`define PCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* sv/pcs_pkg.sv */
// types, codes and constants of the pci configuration space scanner
// used by pcs_regs, pcs_step and pci_config_space_scanner_core
`timescale 1ns / 1ps

package pcs_pkg;

  // scan limits
  localparam int unsigned BusCount   = 256;
  localparam int unsigned DevPerBus  = 32;
  localparam int unsigned FuncPerDev = 8;

  // config dword indexes
  localparam logic [5:0] REG_NONE   = 6'd0;
  localparam logic [5:0] REG_CLASS  = 6'd2;
  localparam logic [5:0] REG_HEADER = 6'd3;
  localparam logic [5:0] REG_BUSNUM = 6'd6;

  // register indexes of the apb port
  localparam logic [2:0] CFG_SEARCH_MODE   = 3'd0;
  localparam logic [2:0] CFG_CLASS_CODE    = 3'd1;
  localparam logic [2:0] CFG_CLASS_WILD    = 3'd2;
  localparam logic [2:0] CFG_SUBCLASS_CODE = 3'd3;
  localparam logic [2:0] CFG_SUBCLASS_WILD = 3'd4;
  localparam logic [2:0] CFG_INSTANCE_IDX  = 3'd5;
  localparam logic [2:0] CFG_TARGET_BUS    = 3'd6;

  // input kinds
  localparam logic KIND_START    = 1'b0;
  localparam logic KIND_RESPONSE = 1'b1;

  // search modes
  localparam logic MODE_DEVICE = 1'b0;
  localparam logic MODE_BRIDGE = 1'b1;

  typedef enum logic [1:0] {
    RK_READ  = 2'd0,
    RK_FOUND = 2'd1,
    RK_NONE  = 2'd2
  } rkind_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_CLASS  = 4'b0010,
    PH_HEADER = 4'b0100,
    PH_BUSNUM = 4'b1000
  } phase_e;

  typedef struct packed {
    logic        search_mode;
    logic [7:0]  class_code;
    logic        class_wildcard;
    logic [7:0]  subclass_code;
    logic        subclass_wildcard;
    logic [15:0] instance_index;
    logic [7:0]  target_bus;
  } cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  bus;
    logic [4:0]  dev;
    logic [2:0]  fn;
    logic        multi;
    logic [31:0] saved;
    logic [15:0] skip;
  } st_t;

  typedef struct packed {
    rkind_e     kind;
    logic [7:0] bus;
    logic [4:0] dev;
    logic [2:0] fn;
    logic [5:0] regidx;
  } res_t;

  typedef struct packed {
    st_t  st;
    logic emit;
    res_t res;
  } step_t;

endpackage

/* sv/pcs_regs.sv */
// apb register file of the scanner: search mode, class match, instance index and bridge target
// depends on pcs_pkg
`timescale 1ns / 1ps

module pcs_regs import pcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t        cfg_q;
  logic        wr_en;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q                   <= '0;
      cfg_q.class_wildcard    <= 1'b1;
      cfg_q.subclass_wildcard <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        CFG_SEARCH_MODE:   cfg_q.search_mode       <= pwdata[0];
        CFG_CLASS_CODE:    cfg_q.class_code        <= pwdata[7:0];
        CFG_CLASS_WILD:    cfg_q.class_wildcard    <= pwdata[0];
        CFG_SUBCLASS_CODE: cfg_q.subclass_code     <= pwdata[7:0];
        CFG_SUBCLASS_WILD: cfg_q.subclass_wildcard <= pwdata[0];
        CFG_INSTANCE_IDX:  cfg_q.instance_index    <= pwdata[15:0];
        CFG_TARGET_BUS:    cfg_q.target_bus        <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      CFG_SEARCH_MODE:   prdata = {31'd0, cfg_q.search_mode};
      CFG_CLASS_CODE:    prdata = {24'd0, cfg_q.class_code};
      CFG_CLASS_WILD:    prdata = {31'd0, cfg_q.class_wildcard};
      CFG_SUBCLASS_CODE: prdata = {24'd0, cfg_q.subclass_code};
      CFG_SUBCLASS_WILD: prdata = {31'd0, cfg_q.subclass_wildcard};
      CFG_INSTANCE_IDX:  prdata = {16'd0, cfg_q.instance_index};
      CFG_TARGET_BUS:    prdata = {24'd0, cfg_q.target_bus};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

/* sv/pcs_step.sv */
// next-state and result logic of the scanner for one registered input item
// depends on pcs_pkg
`timescale 1ns / 1ps

module pcs_step import pcs_pkg::*; (
  input  st_t         st_i,
  input  cfg_t        cfg_i,
  input  logic        kind_i,
  input  logic [31:0] data_i,
  output step_t       step_o
);

  // issue a config read at the current location
  function automatic step_t req(input st_t s, input phase_e ph, input logic [5:0] r);
    step_t o;
    o.st         = s;
    o.st.phase   = ph;
    o.emit       = 1'b1;
    o.res.kind   = RK_READ;
    o.res.bus    = s.bus;
    o.res.dev    = s.dev;
    o.res.fn     = s.fn;
    o.res.regidx = r;
    return o;
  endfunction

  // end the search, found carries the location, not-found carries zeros
  function automatic step_t fin(input st_t s, input rkind_e k);
    step_t o;
    o.st         = s;
    o.st.phase   = PH_IDLE;
    o.emit       = 1'b1;
    o.res.kind   = k;
    o.res.bus    = (k == RK_FOUND) ? s.bus : 8'd0;
    o.res.dev    = (k == RK_FOUND) ? s.dev : 5'd0;
    o.res.fn     = (k == RK_FOUND) ? s.fn : 3'd0;
    o.res.regidx = REG_NONE;
    return o;
  endfunction

  // next function, device or bus (next bus in device mode only)
  function automatic step_t advance(input st_t s, input logic mode);
    st_t        n;
    logic [3:0] nf;
    logic [3:0] lim;
    logic [5:0] nd;
    logic [8:0] nb;
    step_t      o;
    n   = s;
    nf  = {1'b0, s.fn} + 4'd1;
    lim = s.multi ? 4'(FuncPerDev) : 4'd1;
    nd  = {1'b0, s.dev} + 6'd1;
    nb  = {1'b0, s.bus} + 9'd1;
    if (nf < lim) begin
      n.fn = nf[2:0];
      o    = req(n, PH_CLASS, REG_CLASS);
    end else begin
      n.fn    = 3'd0;
      n.multi = 1'b0;
      if (nd < 6'(DevPerBus)) begin
        n.dev = nd[4:0];
        o     = req(n, PH_CLASS, REG_CLASS);
      end else begin
        n.dev = 5'd0;
        if (mode == MODE_DEVICE && nb < 9'(BusCount)) begin
          n.bus = nb[7:0];
          o     = req(n, PH_CLASS, REG_CLASS);
        end else begin
          o = fin(n, RK_NONE);
        end
      end
    end
    return o;
  endfunction

  // class match against the saved class dword with instance skipping
  function automatic step_t judge(input st_t s, input cfg_t c);
    st_t   n;
    logic  hit;
    step_t o;
    n   = s;
    hit = (c.class_wildcard || s.saved[31:24] == c.class_code) &&
          (c.subclass_wildcard || s.saved[23:16] == c.subclass_code);
    if (hit && s.skip == 16'd0) begin
      o = fin(n, RK_FOUND);
    end else begin
      if (hit) n.skip = s.skip - 16'd1;
      o = advance(n, c.search_mode);
    end
    return o;
  endfunction

  always_comb begin
    st_t n;
    n      = st_i;
    step_o = '0;
    step_o.st = st_i;
    if (kind_i == KIND_START) begin
      // fresh search from bus 0 device 0 function 0
      n.bus   = 8'd0;
      n.dev   = 5'd0;
      n.fn    = 3'd0;
      n.multi = 1'b0;
      n.saved = 32'd0;
      n.skip  = cfg_i.instance_index;
      step_o  = req(n, PH_CLASS, REG_CLASS);
    end else begin
      case (st_i.phase)
        PH_CLASS: begin
          if (data_i == 32'hffff_ffff) begin
            step_o = advance(n, cfg_i.search_mode);
          end else begin
            n.saved = data_i;
            if (cfg_i.search_mode == MODE_DEVICE && st_i.multi) begin
              step_o = judge(n, cfg_i);
            end else begin
              step_o = req(n, PH_HEADER, REG_HEADER);
            end
          end
        end
        PH_HEADER: begin
          if (data_i[23]) n.multi = 1'b1;
          if (cfg_i.search_mode == MODE_DEVICE) begin
            step_o = judge(n, cfg_i);
          end else if (data_i[22:16] != 7'd1) begin
            step_o = advance(n, cfg_i.search_mode);
          end else begin
            step_o = req(n, PH_BUSNUM, REG_BUSNUM);
          end
        end
        PH_BUSNUM: begin
          // secondary..subordinate must hold the target bus
          if (data_i[15:8] <= cfg_i.target_bus && data_i[23:16] >= cfg_i.target_bus) begin
            step_o = fin(n, RK_FOUND);
          end else begin
            step_o = advance(n, cfg_i.search_mode);
          end
        end
        default: begin
          // response with no search running is dropped
          step_o.st.phase = PH_IDLE;
          step_o.emit     = 1'b0;
        end
      endcase
    end
  end

endmodule

/* sv/pci_config_space_scanner_core.sv */
// top level of the pci configuration space scanner
// depends on pcs_pkg, pcs_regs, pcs_step and assert_macros.svh
//
//  channel   dir   handshake                   payload
//  s_axis    in    tvalid/tready               tuser kind, tdata read_data
//  m_axis    out   tvalid/tready               tuser result_kind, tdata location
//  apb       in    psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// one item per cycle sustained while the result stream does not stall; an accepted item passes
// the input register, then the step logic, then the result register
// the scan state updates in the same cycle as the result register
// reset clears the scan state, the valid flags of the stages and the config registers to their defaults
// a stalled result holds the input register, which then holds s_axis_tready low
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pci_config_space_scanner_core import pcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] read_data
  input  logic        s_axis_tuser,   // [0] kind
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] bus, [12:8] device, [15:13] function,
                                      // [21:16] register_index, [23:22] zero
  output logic [1:0]  m_axis_tuser    // [1:0] result_kind
);

  cfg_t        cfg;
  st_t         st_q;
  step_t       step;
  logic        s1_valid_q;
  logic        s1_kind_q;
  logic [31:0] s1_data_q;
  logic        out_valid_q;
  res_t        out_res_q;
  logic        out_free;
  logic        go;

  pcs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pcs_step u_step (
    .st_i   (st_q),
    .cfg_i  (cfg),
    .kind_i (s1_kind_q),
    .data_i (s1_data_q),
    .step_o (step)
  );

  // flow control
  assign out_free      = !out_valid_q || m_axis_tready;
  assign go            = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_kind_q <= s_axis_tuser;
      s1_data_q <= s_axis_tdata;
    end
  end

  // scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= '0;
      st_q.phase <= PH_IDLE;
    end else if (go) begin
      st_q <= step.st;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go) begin
      out_valid_q <= step.emit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && step.emit) begin
      out_res_q <= step.res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.kind;
  assign m_axis_tdata  = {2'b00, out_res_q.regidx, out_res_q.fn, out_res_q.dev,
                          out_res_q.bus};

  // checks
  `PCS_ASSERT(a_none_zero,
    (m_axis_tvalid && m_axis_tuser == RK_NONE) |-> (m_axis_tdata == 24'd0),
    "not-found result with nonzero location")
  `PCS_ASSERT(a_start_class,
    (go && s1_kind_q == KIND_START) |=>
      (st_q.phase == PH_CLASS && m_axis_tvalid && m_axis_tdata[21:16] == REG_CLASS),
    "start did not request the class dword")
  `PCS_ASSERT(a_read_busy,
    (go && step.emit && step.res.kind == RK_READ) |=> (st_q.phase != PH_IDLE),
    "read request left the scanner idle")
  `PCS_ASSERT(a_s1_hold,
    (s1_valid_q && !out_free) |=>
      (s1_valid_q && $stable(s1_data_q) && $stable(s1_kind_q)),
    "input register changed under a stall")
  `PCS_ASSERT_ALWAYS(a_phase_onehot, $onehot(st_q.phase) || !rst_ni,
    "scan phase not one-hot")

endmodule

/* sim/pcs_scan_checker.sv */
// scoreboard for the pci configuration space scanner: tracks apb writes,
// predicts each result from the accepted input stream and compares it
// depends on pcs_pkg
`timescale 1ns / 1ps

module pcs_scan_checker import pcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config port, observed
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  // input stream, observed
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] read_data
  input  logic        s_axis_tuser,   // [0] kind
  // result stream, observed
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // [7:0] bus, [12:8] device, [15:13] function,
                                      // [21:16] register_index, [23:22] zero
  input  logic [1:0]  m_axis_tuser,   // [1:0] result_kind
  // status for the stimulus side
  output int          fail_count_o,
  output int          outstanding_o,
  output phase_e      scan_phase_o
);

  // live register copy
  cfg_t settings_q;

  // predicted scan position
  phase_e      phase_q;
  logic [7:0]  bus_q;
  logic [4:0]  dev_q;
  logic [2:0]  fn_q;
  logic        multi_q;
  logic [31:0] class_word_q;
  logic [15:0] skip_q;

  res_t expected_results[$];
  res_t oldest;
  res_t predicted;
  int   mismatches;

  assign fail_count_o = mismatches;
  assign scan_phase_o = phase_q;

  // result carrying the current location, or zeros for not found
  function automatic res_t located(rkind_e kind, logic [5:0] regidx);
    res_t r;
    r.kind   = kind;
    r.bus    = (kind == RK_NONE) ? 8'd0 : bus_q;
    r.dev    = (kind == RK_NONE) ? 5'd0 : dev_q;
    r.fn     = (kind == RK_NONE) ? 3'd0 : fn_q;
    r.regidx = regidx;
    return r;
  endfunction

  function automatic res_t request_read(phase_e next_phase, logic [5:0] regidx);
    phase_q = next_phase;
    return located(RK_READ, regidx);
  endfunction

  function automatic res_t end_search(rkind_e kind);
    phase_q = PH_IDLE;
    return located(kind, REG_NONE);
  endfunction

  // next function, else next device, else next bus (device mode only)
  function automatic res_t step_to_next_function();
    int unsigned next_fn;
    next_fn = int'(fn_q) + 1;
    if (next_fn < (multi_q ? 8 : 1)) begin
      fn_q = next_fn[2:0];
      return request_read(PH_CLASS, REG_CLASS);
    end
    fn_q    = 3'd0;
    multi_q = 1'b0;
    if (int'(dev_q) + 1 < int'(DevPerBus)) begin
      dev_q = dev_q + 5'd1;
      return request_read(PH_CLASS, REG_CLASS);
    end
    dev_q = 5'd0;
    if (settings_q.search_mode == MODE_DEVICE && int'(bus_q) + 1 < int'(BusCount)) begin
      bus_q = bus_q + 8'd1;
      return request_read(PH_CLASS, REG_CLASS);
    end
    return end_search(RK_NONE);
  endfunction

  // class and subclass match with instance skipping
  function automatic res_t judge_class();
    if ((settings_q.class_wildcard || class_word_q[31:24] == settings_q.class_code) &&
        (settings_q.subclass_wildcard ||
         class_word_q[23:16] == settings_q.subclass_code)) begin
      if (skip_q == 16'd0) return end_search(RK_FOUND);
      skip_q = skip_q - 16'd1;
    end
    return step_to_next_function();
  endfunction

  // one input transaction; returns 0 when it causes no result
  function automatic bit scan_step(logic kind, logic [31:0] data, output res_t r);
    r = '0;
    if (kind == KIND_START) begin
      bus_q        = 8'd0;
      dev_q        = 5'd0;
      fn_q         = 3'd0;
      multi_q      = 1'b0;
      class_word_q = 32'd0;
      skip_q       = settings_q.instance_index;
      r = request_read(PH_CLASS, REG_CLASS);
      return 1'b1;
    end
    case (phase_q)
      PH_CLASS: begin
        if (data == 32'hFFFF_FFFF) begin
          r = step_to_next_function();
        end else begin
          class_word_q = data;
          if (settings_q.search_mode == MODE_DEVICE && multi_q) r = judge_class();
          else r = request_read(PH_HEADER, REG_HEADER);
        end
      end
      PH_HEADER: begin
        if (data[23]) multi_q = 1'b1;
        if (settings_q.search_mode == MODE_DEVICE) r = judge_class();
        else if (data[22:16] != 7'd1) r = step_to_next_function();
        else r = request_read(PH_BUSNUM, REG_BUSNUM);
      end
      PH_BUSNUM: begin
        if (data[15:8] <= settings_q.target_bus && data[23:16] >= settings_q.target_bus)
          r = end_search(RK_FOUND);
        else
          r = step_to_next_function();
      end
      default: begin
        phase_q = PH_IDLE;
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // register write as seen on the apb port
  task automatic write_setting(logic [2:0] idx, logic [31:0] value);
    case (idx)
      CFG_SEARCH_MODE:   settings_q.search_mode       = value[0];
      CFG_CLASS_CODE:    settings_q.class_code        = value[7:0];
      CFG_CLASS_WILD:    settings_q.class_wildcard    = value[0];
      CFG_SUBCLASS_CODE: settings_q.subclass_code     = value[7:0];
      CFG_SUBCLASS_WILD: settings_q.subclass_wildcard = value[0];
      CFG_INSTANCE_IDX:  settings_q.instance_index    = value[15:0];
      CFG_TARGET_BUS:    settings_q.target_bus        = value[7:0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settings_q.search_mode       = MODE_DEVICE;
      settings_q.class_code        = 8'd0;
      settings_q.class_wildcard    = 1'b1;
      settings_q.subclass_code     = 8'd0;
      settings_q.subclass_wildcard = 1'b1;
      settings_q.instance_index    = 16'd0;
      settings_q.target_bus        = 8'd0;
      phase_q      = PH_IDLE;
      bus_q        = 8'd0;
      dev_q        = 5'd0;
      fn_q         = 3'd0;
      multi_q      = 1'b0;
      class_word_q = 32'd0;
      skip_q       = 16'd0;
      expected_results.delete();
      outstanding_o = 0;
    end else begin
      // result transaction against the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual kind %0d tdata %h",
                   $time, m_axis_tuser, m_axis_tdata);
          mismatches++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("result_kind", int'(oldest.kind), int'(m_axis_tuser));
          check_field("bus_number", int'(oldest.bus), int'(m_axis_tdata[7:0]));
          check_field("device_number", int'(oldest.dev), int'(m_axis_tdata[12:8]));
          check_field("function_number", int'(oldest.fn), int'(m_axis_tdata[15:13]));
          check_field("register_index", int'(oldest.regidx), int'(m_axis_tdata[21:16]));
          check_field("tdata padding", 0, int'(m_axis_tdata[23:22]));
        end
      end
      // register write
      if (psel && penable && pwrite && pready) write_setting(paddr[4:2], pwdata);
      // input transaction
      if (s_axis_tvalid && s_axis_tready &&
          scan_step(s_axis_tuser, s_axis_tdata, predicted))
        expected_results.push_back(predicted);
      outstanding_o = expected_results.size();
    end
  end

endmodule

/* sim/pci_config_space_scanner_core_tb.sv */
// top of the scanner testbench: clock, reset, apb setup and stream stimulus
// with random stalls; prediction and checks live in pcs_scan_checker
// depends on pcs_pkg, pcs_scan_checker and pci_config_space_scanner_core
`timescale 1ns / 1ps

module pci_config_space_scanner_core_tb;
  import pcs_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_AFTER    = 150;
  localparam int HOLD_CYCLES   = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  int     fail_count;
  int     outstanding;
  phase_e scan_phase;
  int     cycle_count;

  // stimulus shaping state
  bit         idle_on;
  int         absent_pct;
  logic [7:0] cur_class;
  logic [7:0] cur_subclass;
  logic [7:0] cur_target;

  pci_config_space_scanner_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  pcs_scan_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .scan_phase_o  (scan_phase)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one input transaction after a random gap
  task automatic send_item(logic kind, logic [31:0] word);
    int gap;
    gap = idle_on ? $urandom_range(16, 0) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // stop sending and wait until every predicted result has been taken
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // apb write, psel stays high so writes can run back to back
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
  endtask

  task automatic apply_settings(logic mode, logic [7:0] cls, logic cls_any,
                                logic [7:0] sub, logic sub_any,
                                logic [15:0] skip, logic [7:0] tgt);
    drain();
    write_reg(CFG_SEARCH_MODE,   {31'd0, mode});
    write_reg(CFG_CLASS_CODE,    {24'd0, cls});
    write_reg(CFG_CLASS_WILD,    {31'd0, cls_any});
    write_reg(CFG_SUBCLASS_CODE, {24'd0, sub});
    write_reg(CFG_SUBCLASS_WILD, {31'd0, sub_any});
    write_reg(CFG_INSTANCE_IDX,  {16'd0, skip});
    write_reg(CFG_TARGET_BUS,    {24'd0, tgt});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_class    = cls;
    cur_subclass = sub;
    cur_target   = tgt;
  endtask

  // response dword shaped for the read the scanner is waiting on
  function automatic logic [31:0] shaped_word(bit noisy);
    logic [31:0] w;
    w = $urandom;
    if (noisy && $urandom_range(9, 0) == 0) return w;
    case (scan_phase)
      PH_CLASS: begin
        if ($urandom_range(99, 0) < absent_pct) begin
          w = 32'hFFFF_FFFF;
        end else begin
          if ($urandom_range(1, 0) != 0) w[31:24] = cur_class;
          if ($urandom_range(1, 0) != 0) w[23:16] = cur_subclass;
        end
      end
      PH_HEADER: begin
        if ($urandom_range(9, 0) < 6) w[22:16] = 7'd1;
      end
      PH_BUSNUM: begin
        if ($urandom_range(9, 0) < 7) w[15:8] = 8'($urandom_range(cur_target, 0));
        if ($urandom_range(9, 0) < 7) w[23:16] = 8'($urandom_range(255, cur_target));
      end
      default: ;
    endcase
    return w;
  endfunction

  // mostly well-formed searches, some abandoned, some stray responses
  task automatic run_searches(int count);
    int   sent;
    int   pick;
    logic kind;
    logic [31:0] word;
    sent = 0;
    idle_on = ($urandom_range(3, 0) != 0);
    while (sent < count) begin
      pick = $urandom_range(99, 0);
      if (scan_phase == PH_IDLE) kind = (pick < 85) ? KIND_START : KIND_RESPONSE;
      else kind = (pick < 3) ? KIND_START : KIND_RESPONSE;
      if (kind == KIND_START) begin
        absent_pct = ($urandom_range(4, 0) == 0) ? 90 : 25;
        word = $urandom;
      end else begin
        word = shaped_word(1'b1);
      end
      if (kind == KIND_START || scan_phase != PH_IDLE) sent++;
      send_item(kind, word);
    end
    idle_on = 1'b1;
  endtask

  // result side: random stalls plus one long hold-off
  initial begin : result_sink
    int  wait_cycles;
    int  results_taken;
    bit  held;
    m_axis_tready = 1'b0;
    results_taken = 0;
    held = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!held && results_taken >= HOLD_AFTER) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      wait_cycles = idle_on ? $urandom_range(16, 0) : 0;
      if (wait_cycles != 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      results_taken++;
      @(negedge clk_i);
    end
  end

  // main stimulus
  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = 5'd0;
    pwdata        = 32'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = KIND_START;
    s_axis_tdata  = 32'd0;
    idle_on       = 1'b1;
    absent_pct    = 25;
    cur_class     = 8'd0;
    cur_subclass  = 8'd0;
    cur_target    = 8'd0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: device mode, both wildcards
    send_item(KIND_RESPONSE, 32'hFFFF_FFFF);   // stray response while idle
    send_item(KIND_START,    32'h0000_0000);
    send_item(KIND_RESPONSE, 32'hFFFF_FFFF);   // dev 0 absent
    send_item(KIND_RESPONSE, 32'h0000_0000);   // dev 1 class
    send_item(KIND_RESPONSE, 32'h0080_0000);   // multifunction header, first hit

    // exact class match, skip one instance
    apply_settings(MODE_DEVICE, 8'hFF, 1'b0, 8'h00, 1'b0, 16'd1, 8'h00);
    send_item(KIND_START,    32'hFFFF_FFFF);
    send_item(KIND_RESPONSE, 32'hFF00_1234);
    send_item(KIND_RESPONSE, 32'hFFFF_FFFF);   // header with multifunction bit
    send_item(KIND_RESPONSE, 32'hFE00_0000);   // fn 1 class mismatch
    send_item(KIND_RESPONSE, 32'hFF00_0000);   // fn 2 found
    send_item(KIND_START,    32'h1234_5678);
    send_item(KIND_RESPONSE, 32'hFF01_0000);
    send_item(KIND_START,    32'h0000_0000);   // restart mid search
    send_item(KIND_RESPONSE, 32'hFF00_0000);
    send_item(KIND_RESPONSE, 32'h0000_0000);   // single function, skipped match

    // bridge search for the top bus number
    apply_settings(MODE_BRIDGE, 8'h00, 1'b1, 8'h00, 1'b1, 16'd0, 8'hFF);
    send_item(KIND_START,    32'h0000_0000);
    send_item(KIND_RESPONSE, 32'h0604_0000);
    send_item(KIND_RESPONSE, 32'h007F_0000);   // header type not a bridge
    send_item(KIND_RESPONSE, 32'h0604_0000);
    send_item(KIND_RESPONSE, 32'h0081_0000);   // multifunction bridge
    send_item(KIND_RESPONSE, 32'h00FE_FF00);   // range misses target
    send_item(KIND_RESPONSE, 32'h0000_0000);
    send_item(KIND_RESPONSE, 32'h0001_0000);
    send_item(KIND_RESPONSE, 32'h00FF_FF00);   // range holds target

    // random searches over several settings
    apply_settings(MODE_DEVICE, 8'h00, 1'b0, 8'hFF, 1'b0, 16'd0, 8'h00);
    run_searches(100);
    apply_settings(MODE_DEVICE, 8'hFF, 1'b0, 8'h00, 1'b1, 16'd2, 8'hFF);
    run_searches(100);
    apply_settings(MODE_BRIDGE, 8'h00, 1'b1, 8'h00, 1'b1, 16'd0, 8'h00);
    run_searches(100);
    apply_settings(MODE_BRIDGE, 8'hFF, 1'b0, 8'hFF, 1'b0, 16'd3, 8'hFF);
    run_searches(100);
    for (int p = 0; p < 5; p++) begin
      apply_settings(1'($urandom_range(1, 0)), 8'($urandom_range(255, 0)),
                     1'($urandom_range(1, 0)), 8'($urandom_range(255, 0)),
                     1'($urandom_range(1, 0)), 16'($urandom_range(3, 0)),
                     8'($urandom_range(255, 0)));
      run_searches(100);
    end

    drain();
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
